>>> hw/rtl/sfc_pkg.sv
// sfc_pkg: types, widths and codes for the sphere frustum cull core
// no dependencies; used by sphere_frustum_cull_core
package sfc_pkg;

  localparam int FRAC_BITS = 16;
  // product element width after the floor shift
  localparam int CW  = 66 - FRAC_BITS;
  // plane coefficient width
  localparam int NW  = CW + 1;
  // plane distance width
  localparam int DW  = NW + 34;
  // accumulator width
  localparam int QW  = 2 * DW;
  // multiplier operand width
  localparam int MRW = 2 * NW + 2;
  localparam int BCW = $clog2(MRW);

  localparam logic [31:0] FIX_ONE = 32'(64'd1 << FRAC_BITS);

  localparam logic [BCW-1:0] BW_32  = BCW'(31);
  localparam logic [BCW-1:0] BW_N   = BCW'(NW - 1);
  localparam logic [BCW-1:0] BW_D   = BCW'(DW - 1);
  localparam logic [BCW-1:0] BW_NN  = BCW'(MRW - 1);

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_LOAD_P = 2'd1,
    OP_LOAD_M = 2'd2,
    OP_TEST = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MAT, S_CST, S_PLN, S_DOT, S_DCK, S_NN, S_RR, S_RN, S_DD, S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic        visible;
    logic [31:0] culled_total;
  } out_item_t;

endpackage

>>> hw/rtl/sphere_frustum_cull_core.sv
// sphere_frustum_cull_core: sphere against view frustum test with matrix store
// depends on sfc_pkg; one shared shift-add multiplier under a sequencer
//
// usage:
//   input channel in_valid / in_stall / in_item carries one operation per item:
//   new frame, load a projection element, load a modelview element, or test a
//   sphere. every item gives exactly one result item on out_valid / out_stall /
//   out_item with the visible flag and the running cull count.
//   frame and load items give their result the cycle after acceptance. a
//   sphere test first forms P*M, 64 products plus storing its 16 elements,
//   then up to six planes: the distance, and for a plane with the centre
//   behind it and a nonzero radius, the exact squared compare.
//   one item at a time; the shift-add multiplier works one bit a cycle.
//   in_stall is high while an item is at work.
//   reset: both matrices return to identity, the cull count to zero, no
//   result pending.
//   a stalled receiver holds the result register; the block then takes a new
//   item only once that result has been taken.
module sphere_frustum_cull_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sfc_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sfc_pkg::out_item_t   out_item
);

  localparam int CW  = sfc_pkg::CW;
  localparam int NW  = sfc_pkg::NW;
  localparam int DW  = sfc_pkg::DW;
  localparam int QW  = sfc_pkg::QW;
  localparam int MRW = sfc_pkg::MRW;
  localparam int BCW = sfc_pkg::BCW;
  localparam int FB  = sfc_pkg::FRAC_BITS;

  sfc_pkg::state_t state_r, state_nxt;

  logic signed [31:0] proj_r [16];
  logic signed [31:0] mv_r [16];
  logic signed [CW-1:0] c_r [16];

  logic [QW-1:0]  acc_r, acc_nxt, mc_r, mc_nxt, rhs_r, rhs_nxt;
  logic [MRW-1:0] mr_r, mr_nxt, nn_r, nn_nxt;
  logic [BCW-1:0] bc_r, bc_nxt, bw_r, bw_nxt;
  logic [DW-1:0]  d_r, d_nxt;
  logic [3:0]     e_r, e_nxt;
  logic [1:0]     k_r, k_nxt, j_r, j_nxt;
  logic [2:0]     p_r, p_nxt;
  logic           cull_r, cull_nxt;
  logic signed [31:0] cen_r [3];
  logic [30:0]    rad_r;
  logic [31:0]    cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  sfc_pkg::out_item_t out_item_r, out_item_nxt;

  logic           in_acc, last, out_free, n_zero, d_neg, d_zero;
  logic [QW-1:0]  acc_step;
  logic signed [NW-1:0] nv [4];
  logic [1:0]     prow;
  logic [3:0]     pi_nx, mi_nx;
  logic [1:0]     j_inc;

  assign in_stall  = (state_r != sfc_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  // shared multiplier step, sign bit of the multiplier weighs negative
  assign last     = (bc_r == bw_r);
  assign acc_step = mr_r[0] ? (last ? acc_r - mc_r : acc_r + mc_r) : acc_r;

  // plane coefficients
  assign prow = p_r[2:1];
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (p_r[0]) begin
        nv[j] = NW'(c_r[4*j+3]) - NW'(c_r[4*j + int'(prow)]);
      end else begin
        nv[j] = NW'(c_r[4*j+3]) + NW'(c_r[4*j + int'(prow)]);
      end
    end
  end
  assign n_zero = (nv[0] == '0) && (nv[1] == '0) && (nv[2] == '0);
  assign d_neg  = acc_r[DW-1];
  assign d_zero = (acc_r[DW-1:0] == '0);
  assign j_inc  = j_r + 2'd1;

  // operand indexes for the matrix product
  assign pi_nx  = {k_r + 2'd1, e_r[1:0]};
  assign mi_nx  = {e_r[3:2], k_r + 2'd1};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfc_pkg::S_IDLE: begin
        if (in_acc && in_item.operation == sfc_pkg::OP_TEST) state_nxt = sfc_pkg::S_MAT;
      end
      sfc_pkg::S_MAT: begin
        if (last && k_r == 2'd3) state_nxt = sfc_pkg::S_CST;
      end
      sfc_pkg::S_CST: begin
        state_nxt = (e_r == 4'd15) ? sfc_pkg::S_PLN : sfc_pkg::S_MAT;
      end
      sfc_pkg::S_PLN: begin
        if (!n_zero) state_nxt = sfc_pkg::S_DOT;
        else if (p_r == 3'd5) state_nxt = sfc_pkg::S_FIN;
      end
      sfc_pkg::S_DOT: begin
        if (last && j_r == 2'd2) state_nxt = sfc_pkg::S_DCK;
      end
      sfc_pkg::S_DCK: begin
        if (rad_r == '0) begin
          if (d_neg || d_zero || p_r == 3'd5) state_nxt = sfc_pkg::S_FIN;
          else state_nxt = sfc_pkg::S_PLN;
        end else if (d_neg) begin
          state_nxt = sfc_pkg::S_NN;
        end else begin
          state_nxt = (p_r == 3'd5) ? sfc_pkg::S_FIN : sfc_pkg::S_PLN;
        end
      end
      sfc_pkg::S_NN: begin
        if (last && j_r == 2'd2) state_nxt = sfc_pkg::S_RR;
      end
      sfc_pkg::S_RR: begin
        if (last) state_nxt = sfc_pkg::S_RN;
      end
      sfc_pkg::S_RN: begin
        if (last) state_nxt = sfc_pkg::S_DD;
      end
      sfc_pkg::S_DD: begin
        if (last) begin
          if (acc_step >= rhs_r || p_r == 3'd5) state_nxt = sfc_pkg::S_FIN;
          else state_nxt = sfc_pkg::S_PLN;
        end
      end
      sfc_pkg::S_FIN: begin
        if (out_free) state_nxt = sfc_pkg::S_IDLE;
      end
      default: state_nxt = sfc_pkg::S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    mr_nxt = mr_r;
    bc_nxt = bc_r;
    bw_nxt = bw_r;
    rhs_nxt = rhs_r;
    nn_nxt = nn_r;
    d_nxt = d_r;
    e_nxt = e_r;
    k_nxt = k_r;
    j_nxt = j_r;
    p_nxt = p_r;
    cull_nxt = cull_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt = out_item_r;
    if (state_r != sfc_pkg::S_IDLE && state_r != sfc_pkg::S_CST &&
        state_r != sfc_pkg::S_PLN && state_r != sfc_pkg::S_DCK &&
        state_r != sfc_pkg::S_FIN) begin
      acc_nxt = acc_step;
      mc_nxt = mc_r << 1;
      mr_nxt = mr_r >> 1;
      bc_nxt = bc_r + BCW'(1);
    end
    case (state_r)
      sfc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_item.operation == sfc_pkg::OP_TEST) begin
            e_nxt = '0;
            k_nxt = '0;
            acc_nxt = '0;
            bc_nxt = '0;
            bw_nxt = sfc_pkg::BW_32;
            mc_nxt = QW'(proj_r[0]);
            mr_nxt = MRW'(mv_r[0]);
          end else begin
            if (in_item.operation == sfc_pkg::OP_FRAME) cnt_nxt = '0;
            out_valid_nxt = 1'b1;
            out_item_nxt.visible = 1'b0;
            out_item_nxt.culled_total = cnt_nxt;
          end
        end
      end
      sfc_pkg::S_MAT: begin
        if (last && k_r != 2'd3) begin
          k_nxt = k_r + 2'd1;
          bc_nxt = '0;
          mc_nxt = QW'(proj_r[pi_nx]);
          mr_nxt = MRW'(mv_r[mi_nx]);
        end
      end
      sfc_pkg::S_CST: begin
        if (e_r == 4'd15) begin
          p_nxt = '0;
        end else begin
          e_nxt = e_r + 4'd1;
          k_nxt = '0;
          acc_nxt = '0;
          bc_nxt = '0;
          mc_nxt = QW'(proj_r[{2'd0, e_nxt[1:0]}]);
          mr_nxt = MRW'(mv_r[{e_nxt[3:2], 2'd0}]);
        end
      end
      sfc_pkg::S_PLN: begin
        if (!n_zero) begin
          acc_nxt = QW'(nv[3]) << FB;
          mc_nxt = QW'(nv[0]);
          mr_nxt = MRW'(cen_r[0]);
          bc_nxt = '0;
          bw_nxt = sfc_pkg::BW_32;
          j_nxt = '0;
        end else if (p_r == 3'd5) begin
          cull_nxt = 1'b0;
        end else begin
          p_nxt = p_r + 3'd1;
        end
      end
      sfc_pkg::S_DOT: begin
        if (last && j_r != 2'd2) begin
          j_nxt = j_inc;
          bc_nxt = '0;
          mc_nxt = QW'(nv[j_inc]);
          mr_nxt = MRW'(cen_r[j_inc]);
        end
      end
      sfc_pkg::S_DCK: begin
        d_nxt = acc_r[DW-1:0];
        p_nxt = p_r + 3'd1;
        cull_nxt = 1'b0;
        if (rad_r == '0) begin
          cull_nxt = d_neg || d_zero;
        end else if (d_neg) begin
          p_nxt = p_r;
          acc_nxt = '0;
          mc_nxt = QW'(nv[0]);
          mr_nxt = MRW'(nv[0]);
          bc_nxt = '0;
          bw_nxt = sfc_pkg::BW_N;
          j_nxt = '0;
        end
      end
      sfc_pkg::S_NN: begin
        if (last) begin
          bc_nxt = '0;
          if (j_r == 2'd2) begin
            nn_nxt = acc_step[MRW-1:0];
            acc_nxt = '0;
            mc_nxt = QW'(rad_r);
            mr_nxt = MRW'(rad_r);
            bw_nxt = sfc_pkg::BW_32;
          end else begin
            j_nxt = j_inc;
            mc_nxt = QW'(nv[j_inc]);
            mr_nxt = MRW'(nv[j_inc]);
          end
        end
      end
      sfc_pkg::S_RR: begin
        if (last) begin
          acc_nxt = '0;
          mc_nxt = acc_step;
          mr_nxt = nn_r;
          bc_nxt = '0;
          bw_nxt = sfc_pkg::BW_NN;
        end
      end
      sfc_pkg::S_RN: begin
        if (last) begin
          rhs_nxt = acc_step;
          acc_nxt = '0;
          mc_nxt = QW'(signed'(d_r));
          mr_nxt = MRW'(signed'(d_r));
          bc_nxt = '0;
          bw_nxt = sfc_pkg::BW_D;
        end
      end
      sfc_pkg::S_DD: begin
        if (last) begin
          cull_nxt = (acc_step >= rhs_r);
          p_nxt = p_r + 3'd1;
        end
      end
      sfc_pkg::S_FIN: begin
        if (out_free) begin
          if (cull_r && cnt_r != '1) cnt_nxt = cnt_r + 32'd1;
          out_valid_nxt = 1'b1;
          out_item_nxt.visible = !cull_r;
          out_item_nxt.culled_total = cnt_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfc_pkg::S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        proj_r[i] <= (i % 5 == 0) ? sfc_pkg::FIX_ONE : '0;
        mv_r[i] <= (i % 5 == 0) ? sfc_pkg::FIX_ONE : '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        case (in_item.operation)
          sfc_pkg::OP_FRAME: begin
            for (int i = 0; i < 16; i++) begin
              proj_r[i] <= (i % 5 == 0) ? sfc_pkg::FIX_ONE : '0;
              mv_r[i] <= (i % 5 == 0) ? sfc_pkg::FIX_ONE : '0;
            end
          end
          sfc_pkg::OP_LOAD_P: proj_r[in_item.element_index] <= in_item.element_value;
          sfc_pkg::OP_LOAD_M: mv_r[in_item.element_index] <= in_item.element_value;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    mr_r <= mr_nxt;
    bc_r <= bc_nxt;
    bw_r <= bw_nxt;
    rhs_r <= rhs_nxt;
    nn_r <= nn_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
    k_r <= k_nxt;
    j_r <= j_nxt;
    p_r <= p_nxt;
    cull_r <= cull_nxt;
    out_item_r <= out_item_nxt;
    if (state_r == sfc_pkg::S_CST) c_r[e_r] <= acc_r[FB+CW-1:FB];
    if (in_acc) begin
      cen_r[0] <= in_item.center_x;
      cen_r[1] <= in_item.center_y;
      cen_r[2] <= in_item.center_z;
      rad_r <= in_item.radius;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == sfc_pkg::S_IDLE)
    else $error("item accepted while busy");

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != sfc_pkg::S_IDLE |=> cnt_r >= $past(cnt_r))
    else $error("cull count fell during a test");

  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sfc_pkg::S_MAT || state_r == sfc_pkg::S_DOT ||
     state_r == sfc_pkg::S_DD) |-> bc_r <= bw_r)
    else $error("multiplier ran past its operand");

  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sfc_pkg::S_FIN && out_free) |=> out_valid_r)
    else $error("finished test gave no result");
`endif

endmodule
